/* rtl/sbfd_pkg.sv */
// Shared types and constants for the binary block deframer.
// Holds the phase and event codes, the per-word result record and the CRC constants.
// Depends on nothing; used by every other file of the block.
package sbfd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CrcW   = 16;
  localparam int unsigned IdW    = 13;
  localparam int unsigned RevW   = 3;
  localparam int unsigned LenW   = 16;
  localparam int unsigned EventW = 3;
  localparam int unsigned OutDataW = 48;

  localparam logic [ByteW-1:0] Preamble1   = 8'h24;
  localparam logic [ByteW-1:0] Preamble2   = 8'h40;
  localparam logic [IdW-1:0]   EncapId     = 13'd4097;
  localparam logic [LenW-1:0]  CaptureOfs  = 16'd14;
  localparam logic [LenW-1:0]  HeaderBytes = 16'd8;
  localparam logic [CrcW-1:0]  CrcPoly     = 16'h1021;
  localparam logic [ByteW-1:0] EncapNmea   = 8'd4;
  localparam logic [ByteW-1:0] EncapRtcm   = 8'd2;

  typedef enum logic [8:0] {
    PH_IDLE   = 9'b0_0000_0001,
    PH_PRE2   = 9'b0_0000_0010,
    PH_CRC_LO = 9'b0_0000_0100,
    PH_CRC_HI = 9'b0_0000_1000,
    PH_ID_LO  = 9'b0_0001_0000,
    PH_ID_HI  = 9'b0_0010_0000,
    PH_LEN_LO = 9'b0_0100_0000,
    PH_LEN_HI = 9'b0_1000_0000,
    PH_BODY   = 9'b1_0000_0000
  } sbfd_phase_t;

  typedef enum logic [EventW-1:0] {
    EV_NONE   = 3'd0,
    EV_FRAME  = 3'd1,
    EV_GOOD   = 3'd2,
    EV_BADCRC = 3'd3,
    EV_BADLEN = 3'd4,
    EV_BADPRE = 3'd5
  } sbfd_event_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_echo;
    sbfd_event_t      event_res;
    logic [IdW-1:0]   block_id;
    logic [RevW-1:0]  block_rev;
    logic [LenW-1:0]  block_length;
    logic             encap_nmea;
    logic             encap_rtcm;
  } sbfd_res_t;

endpackage

/* rtl/sbfd_crc16.sv */
// Byte-wide CRC-16-CCITT update (MSB first, unreflected).
// Pure combinational; uses constants from sbfd_pkg.
module sbfd_crc16 (
  input  logic [sbfd_pkg::CrcW-1:0]  crc_in,
  input  logic [sbfd_pkg::ByteW-1:0] data_in,
  output logic [sbfd_pkg::CrcW-1:0]  crc_out
);

  always_comb begin
    logic [sbfd_pkg::CrcW-1:0] c;
    c = crc_in ^ {data_in, {(sbfd_pkg::CrcW-sbfd_pkg::ByteW){1'b0}}};
    for (int i = 0; i < sbfd_pkg::ByteW; i++) begin
      if (c[sbfd_pkg::CrcW-1]) begin
        c = {c[sbfd_pkg::CrcW-2:0], 1'b0} ^ sbfd_pkg::CrcPoly;
      end else begin
        c = {c[sbfd_pkg::CrcW-2:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

/* rtl/sbfd_parse.sv */
// Frame parser: phase machine, header capture, length counter and CRC check.
// Depends on sbfd_pkg and sbfd_crc16; steps once per word when step_en is high.
module sbfd_parse (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  logic [sbfd_pkg::ByteW-1:0] rx_byte,
  input  logic                       accept_bad_crc,
  output sbfd_pkg::sbfd_res_t        res
);

  sbfd_pkg::sbfd_phase_t        phase_r,   phase_nxt;
  logic [sbfd_pkg::CrcW-1:0]    exp_crc_r, exp_crc_nxt;
  logic [sbfd_pkg::CrcW-1:0]    run_crc_r, run_crc_nxt;
  logic [sbfd_pkg::IdW-1:0]     id_r,      id_nxt;
  logic [sbfd_pkg::RevW-1:0]    rev_r,     rev_nxt;
  logic [sbfd_pkg::LenW-1:0]    len_r,     len_nxt;
  logic [sbfd_pkg::LenW-1:0]    left_r,    left_nxt;
  logic [sbfd_pkg::ByteW-1:0]   b14_r,     b14_nxt;

  logic [sbfd_pkg::CrcW-1:0]    crc_upd;
  logic [sbfd_pkg::LenW-1:0]    len_full;
  logic [sbfd_pkg::LenW-1:0]    body_ofs;
  logic [sbfd_pkg::LenW-1:0]    left_dec;
  sbfd_pkg::sbfd_event_t        ev;
  logic                         nmea;
  logic                         rtcm;

  sbfd_crc16 u_crc (
    .crc_in  (run_crc_r),
    .data_in (rx_byte),
    .crc_out (crc_upd)
  );

  assign len_full = {rx_byte, len_r[sbfd_pkg::ByteW-1:0]};
  assign body_ofs = len_r - left_r;
  assign left_dec = left_r - 16'd1;

  always_comb begin
    phase_nxt   = phase_r;
    exp_crc_nxt = exp_crc_r;
    run_crc_nxt = run_crc_r;
    id_nxt      = id_r;
    rev_nxt     = rev_r;
    len_nxt     = len_r;
    left_nxt    = left_r;
    b14_nxt     = b14_r;
    ev          = sbfd_pkg::EV_FRAME;
    nmea        = 1'b0;
    rtcm        = 1'b0;
    unique case (phase_r)
      sbfd_pkg::PH_PRE2: begin
        if (rx_byte == sbfd_pkg::Preamble2) begin
          phase_nxt = sbfd_pkg::PH_CRC_LO;
        end else begin
          phase_nxt = sbfd_pkg::PH_IDLE;
          ev        = sbfd_pkg::EV_BADPRE;
        end
      end
      sbfd_pkg::PH_CRC_LO: begin
        exp_crc_nxt = {8'h00, rx_byte};
        phase_nxt   = sbfd_pkg::PH_CRC_HI;
      end
      sbfd_pkg::PH_CRC_HI: begin
        exp_crc_nxt = {rx_byte, exp_crc_r[sbfd_pkg::ByteW-1:0]};
        run_crc_nxt = '0;
        phase_nxt   = sbfd_pkg::PH_ID_LO;
      end
      sbfd_pkg::PH_ID_LO: begin
        run_crc_nxt = crc_upd;
        id_nxt      = {5'b0_0000, rx_byte};
        phase_nxt   = sbfd_pkg::PH_ID_HI;
      end
      sbfd_pkg::PH_ID_HI: begin
        run_crc_nxt = crc_upd;
        id_nxt      = {rx_byte[4:0], id_r[sbfd_pkg::ByteW-1:0]};
        rev_nxt     = rx_byte[7:5];
        phase_nxt   = sbfd_pkg::PH_LEN_LO;
      end
      sbfd_pkg::PH_LEN_LO: begin
        run_crc_nxt = crc_upd;
        len_nxt     = {8'h00, rx_byte};
        phase_nxt   = sbfd_pkg::PH_LEN_HI;
      end
      sbfd_pkg::PH_LEN_HI: begin
        run_crc_nxt = crc_upd;
        len_nxt     = len_full;
        // Reject lengths off the 4-byte grid and those with no body
        if (len_full[1:0] == 2'b00 && len_full > sbfd_pkg::HeaderBytes) begin
          left_nxt  = len_full - sbfd_pkg::HeaderBytes;
          phase_nxt = sbfd_pkg::PH_BODY;
        end else begin
          phase_nxt = sbfd_pkg::PH_IDLE;
          ev        = sbfd_pkg::EV_BADLEN;
        end
      end
      sbfd_pkg::PH_BODY: begin
        run_crc_nxt = crc_upd;
        if (body_ofs == sbfd_pkg::CaptureOfs) begin
          b14_nxt = rx_byte;
        end
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt = sbfd_pkg::PH_IDLE;
          if (crc_upd == exp_crc_r || accept_bad_crc) begin
            ev = sbfd_pkg::EV_GOOD;
          end else begin
            ev = sbfd_pkg::EV_BADCRC;
          end
          if (id_r == sbfd_pkg::EncapId) begin
            nmea = (b14_nxt == sbfd_pkg::EncapNmea);
            rtcm = (b14_nxt == sbfd_pkg::EncapRtcm);
          end
        end
      end
      default: begin
        // Idle, and any code that is not one of the phases
        if (rx_byte == sbfd_pkg::Preamble1) begin
          b14_nxt   = '0;
          phase_nxt = sbfd_pkg::PH_PRE2;
        end else begin
          phase_nxt = sbfd_pkg::PH_IDLE;
          ev        = sbfd_pkg::EV_NONE;
        end
      end
    endcase
  end

  always_comb begin
    res.byte_echo    = rx_byte;
    res.event_res    = ev;
    res.block_id     = id_nxt;
    res.block_rev    = rev_nxt;
    res.block_length = len_nxt;
    res.encap_nmea   = nmea;
    res.encap_rtcm   = rtcm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= sbfd_pkg::PH_IDLE;
      exp_crc_r <= '0;
      run_crc_r <= '0;
      id_r      <= '0;
      rev_r     <= '0;
      len_r     <= '0;
      left_r    <= '0;
      b14_r     <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      exp_crc_r <= exp_crc_nxt;
      run_crc_r <= run_crc_nxt;
      id_r      <= id_nxt;
      rev_r     <= rev_nxt;
      len_r     <= len_nxt;
      left_r    <= left_nxt;
      b14_r     <= b14_nxt;
    end
  end

endmodule

/* rtl/sbf_block_deframer_unit.sv */
// Binary block deframer, top level: input register, parser, result register, config bit.
// Each word is held in the input register, then parsed into the result register.
// Throughput: one word per cycle while out_tready is high; single-pass parser step.
// Reset (rst_n low, synchronous): both register stages empty, parser idle, all header
// fields and CRCs zero, accept_bad_crc cleared. Depends on sbfd_pkg and sbfd_parse.
module sbf_block_deframer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // Config: accept_bad_crc
  input  logic                               cfg_wr_en,
  input  logic                               cfg_wr_data,
  // in_tdata: [7:0] rx_byte
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,
  // out_tdata: [7:0] byte_echo, [20:8] block_id, [23:21] block_rev,
  //            [39:24] block_length, [40] encap_nmea, [41] encap_rtcm, [47:42] zero
  // out_tuser: [2:0] event_res
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sbfd_pkg::OutDataW-1:0]      out_tdata,
  output logic [sbfd_pkg::EventW-1:0]        out_tuser
);

  logic                              acc_bad_r;
  logic                              s1_valid_r;
  logic [sbfd_pkg::ByteW-1:0]        s1_byte_r;
  logic                              out_valid_r;
  logic [sbfd_pkg::OutDataW-1:0]     out_data_r;
  logic [sbfd_pkg::EventW-1:0]       out_user_r;
  logic                              s1_fire;
  logic                              in_fire;
  sbfd_pkg::sbfd_res_t               res;

  // Advance the held word into the result register when that register frees up
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  // Take a new word whenever the input register is empty or moving on this cycle
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_bad_r <= 1'b0;
    end else if (cfg_wr_en) begin
      acc_bad_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
    end
  end

  // Parser state steps exactly once per word, as the word leaves the input register
  sbfd_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (s1_fire),
    .rx_byte        (s1_byte_r),
    .accept_bad_crc (acc_bad_r),
    .res            (res)
  );

  // Result register: hold while the sink stalls, load on every advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= {6'b00_0000, res.encap_rtcm, res.encap_nmea, res.block_length,
                     res.block_rev, res.block_id, res.byte_echo};
      out_user_r <= res.event_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Encapsulation flags only ever accompany an end-of-block event
  a_encap_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[40] || out_data_r[41])) |->
      (out_user_r == sbfd_pkg::EV_GOOD || out_user_r == sbfd_pkg::EV_BADCRC))
    else $error("encap flag set without end-of-block event");

  // A word advanced out of the input register must show up as a result
  a_fire_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("advanced word lost before result register");

  // An accepted word must be held in the input register the next cycle
  a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted word not held in input register");

endmodule
